FILE: hdl/prpd_pkg.sv
// Shared types and constants for the palette RLE pixel decoder.
// No dependencies; imported by every module of the decoder.
package prpd_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int CFG_AW          = 4;
  localparam int CFG_DW          = 32;
  localparam int SPAN_W          = 9;
  localparam int PIX_W           = 32;

  typedef enum logic {
    MODE_PAL  = 1'b0,
    MODE_DATA = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MARKER = 2'd2,
    REG_RAW    = 2'd3
  } reg_e;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  marker;
    logic        raw;
  } cfg_t;

  typedef struct packed {
    logic              clear;
    logic [SPAN_W-1:0] count;
  } span_req_t;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

endpackage

FILE: hdl/prpd_cfg_regs.sv
// APB-style configuration registers and frame size product.
// Depends on prpd_pkg.
module prpd_cfg_regs
  import prpd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o,
  output logic              cfg_wr_o,
  output logic [PIX_W-1:0]  total_o
);

  cfg_t             cfg_q, cfg_d;
  logic [PIX_W-1:0] total_q, total_d;
  reg_e             reg_sel;

  assign pready   = 1'b1;
  assign reg_sel  = reg_e'(paddr[3:2]);
  assign cfg_wr_o = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr_o) begin
      unique case (reg_sel)
        REG_WIDTH:  cfg_d.width  = pwdata[15:0];
        REG_HEIGHT: cfg_d.height = pwdata[15:0];
        REG_MARKER: cfg_d.marker = pwdata[7:0];
        REG_RAW:    cfg_d.raw    = pwdata[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = {16'b0, cfg_q.width};
      REG_HEIGHT: prdata = {16'b0, cfg_q.height};
      REG_MARKER: prdata = {24'b0, cfg_q.marker};
      REG_RAW:    prdata = {31'b0, cfg_q.raw};
      default:    prdata = '0;
    endcase
  end

  // zero dimension counts as a one-pixel frame
  always_comb begin
    if (cfg_q.width == '0 || cfg_q.height == '0) begin
      total_d = PIX_W'(1);
    end else begin
      total_d = {16'b0, cfg_q.width} * {16'b0, cfg_q.height};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '{width: 16'd1, height: 16'd1, marker: 8'd0, raw: 1'b0};
      total_q <= PIX_W'(1);
    end else begin
      cfg_q   <= cfg_d;
      total_q <= total_d;
    end
  end

  assign cfg_o   = cfg_q;
  assign total_o = total_q;

endmodule

FILE: hdl/prpd_palette.sv
// Colour store with registered read, plus transparent index tracking.
// Depends on prpd_pkg.
module prpd_palette
  import prpd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [PAL_AW-1:0] wr_idx_i,
  input  logic [23:0]       wr_rgb_i,
  input  logic              rd_en_i,
  input  logic [PAL_AW-1:0] rd_idx_i,
  output logic [23:0]       rd_rgb_o,
  output logic [PAL_AW-1:0] trans_idx_o
);

  logic [23:0]       mem [PALETTE_ENTRIES];
  logic [23:0]       rd_q;
  logic [PAL_AW-1:0] trans_idx_q, trans_idx_d;
  logic              trans_found_q, trans_found_d;
  logic              is_green;

  assign is_green = (wr_rgb_i == 24'h00ff00);

  always_comb begin
    trans_idx_d   = trans_idx_q;
    trans_found_d = trans_found_q;
    if (wr_en_i && is_green && (!trans_found_q || wr_idx_i < trans_idx_q)) begin
      trans_idx_d   = wr_idx_i;
      trans_found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_rgb_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_idx_q   <= '0;
      trans_found_q <= 1'b0;
    end else begin
      trans_idx_q   <= trans_idx_d;
      trans_found_q <= trans_found_d;
    end
  end

  assign rd_rgb_o    = rd_q;
  assign trans_idx_o = trans_idx_q;

endmodule

FILE: hdl/prpd_span.sv
// Span stage: clips spans to the frame, tracks frame position, holds the result beat.
// Depends on prpd_pkg; colour comes from prpd_palette's registered read.
module prpd_span
  import prpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  span_req_t        req_i,
  input  logic [23:0]      rgb_i,
  input  logic [PIX_W-1:0] total_i,
  input  logic             restart_i,
  output logic             can_load_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [7:0]       alpha_o,
  output logic [SPAN_W-1:0] span_length_o,
  output logic             frame_end_o
);

  logic              s1_valid_q, s1_valid_d;
  span_req_t         s1_req_q;
  logic              out_valid_q, out_valid_d;
  logic              adv;
  logic [PIX_W-1:0]  done_q, done_d;
  logic [PIX_W-1:0]  left;
  logic [SPAN_W-1:0] len;
  logic              last;
  logic [7:0]        red_q, green_q, blue_q, alpha_q;
  logic [SPAN_W-1:0] len_q;
  logic              end_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign can_load_o = !s1_valid_q || adv;

  always_comb begin
    left = (done_q < total_i) ? (total_i - done_q) : PIX_W'(1);
    len  = ({{(PIX_W-SPAN_W){1'b0}}, s1_req_q.count} < left) ? s1_req_q.count
                                                               : left[SPAN_W-1:0];
    last = ({{(PIX_W-SPAN_W){1'b0}}, len} == left);
  end

  always_comb begin
    s1_valid_d  = load_i ? 1'b1 : (adv ? 1'b0 : s1_valid_q);
    out_valid_d = adv ? s1_valid_q : out_valid_q;
    done_d      = done_q;
    if (restart_i) begin
      done_d = '0;
    end else if (s1_valid_q && adv) begin
      done_d = last ? '0 : done_q + {{(PIX_W-SPAN_W){1'b0}}, len};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      done_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_req_q <= req_i;
    end
    if (s1_valid_q && adv) begin
      red_q   <= s1_req_q.clear ? 8'd0 : rgb_i[23:16];
      green_q <= s1_req_q.clear ? 8'd0 : rgb_i[15:8];
      blue_q  <= s1_req_q.clear ? 8'd0 : rgb_i[7:0];
      alpha_q <= s1_req_q.clear ? 8'd0 : ALPHA_OPAQUE;
      len_q   <= len;
      end_q   <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign alpha_o       = alpha_q;
  assign span_length_o = len_q;
  assign frame_end_o   = end_q;

endmodule

FILE: hdl/palette_rle_pixel_decoder_core.sv
// Palette RLE pixel decoder top level: configuration registers, beat decode, run state, palette and span stage.
// An emitting input beat is held in the span input register with its palette read, then in the output register.
// Throughput: one input beat per cycle; input stalls only when both stages hold a beat.
// Reset clears run state, frame position, transparent index and registers
// (width 1, height 1, marker 0, run-length mode); palette contents stay undefined.
// Depends on prpd_pkg, prpd_cfg_regs, prpd_palette, prpd_span.
module palette_rle_pixel_decoder_core
  import prpd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  logic [7:0]        pal_index_i,
  input  logic [7:0]        pal_blue_i,
  input  logic [7:0]        pal_green_i,
  input  logic [7:0]        pal_red_i,
  input  logic [7:0]        data_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic [7:0]        alpha_o,
  output logic [SPAN_W-1:0] span_length_o,
  output logic              frame_end_o
);

  cfg_t              cfg;
  logic              cfg_wr;
  logic [PIX_W-1:0]  total;
  logic              can_load;
  logic              accept;
  logic              pal_wr;
  logic              emit;
  logic [7:0]        rd_idx;
  logic              may_clear;
  logic [PAL_AW-1:0] trans_idx;
  logic [23:0]       rd_rgb;
  span_req_t         req;
  logic              await_q, await_d;

  prpd_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .cfg_wr_o (cfg_wr),
    .total_o  (total)
  );

  assign in_stall_o = !can_load;
  assign accept     = in_valid_i && can_load;
  assign pal_wr     = accept && (mode_e'(mode_i) == MODE_PAL);

  always_comb begin
    emit      = 1'b0;
    rd_idx    = data_byte_i;
    may_clear = 1'b1;
    req.count = SPAN_W'(1);
    await_d   = await_q;
    if (cfg_wr) begin
      await_d = 1'b0;
    end else if (accept && mode_e'(mode_i) == MODE_DATA) begin
      if (cfg.raw) begin
        emit      = 1'b1;
        may_clear = 1'b0;
      end else if (await_q) begin
        emit      = 1'b1;
        rd_idx    = cfg.marker;
        req.count = {1'b0, data_byte_i} + SPAN_W'(1);
        await_d   = 1'b0;
      end else if (data_byte_i == cfg.marker) begin
        await_d = 1'b1;
      end else begin
        emit = 1'b1;
      end
    end
    req.clear = may_clear && (rd_idx[PAL_AW-1:0] == trans_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q <= 1'b0;
    end else begin
      await_q <= await_d;
    end
  end

  prpd_palette u_pal (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (pal_wr),
    .wr_idx_i    (pal_index_i[PAL_AW-1:0]),
    .wr_rgb_i    ({pal_red_i, pal_green_i, pal_blue_i}),
    .rd_en_i     (emit),
    .rd_idx_i    (rd_idx[PAL_AW-1:0]),
    .rd_rgb_o    (rd_rgb),
    .trans_idx_o (trans_idx)
  );

  prpd_span u_span (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (emit),
    .req_i         (req),
    .rgb_i         (rd_rgb),
    .total_i       (total),
    .restart_i     (cfg_wr),
    .can_load_o    (can_load),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .alpha_o       (alpha_o),
    .span_length_o (span_length_o),
    .frame_end_o   (frame_end_o)
  );

  a_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> span_length_o != '0)
    else $error("zero-length span beat");

  a_clear_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (alpha_o == ALPHA_OPAQUE ||
                     (alpha_o == 8'd0 && red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0)))
    else $error("transparent beat carries color");

  a_raw_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.raw |-> !await_q)
    else $error("run count pending in raw mode");

  a_raw_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cfg.raw |-> alpha_o == ALPHA_OPAQUE)
    else $error("raw frame produced transparent beat");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for palette_rle_pixel_decoder_core: APB register setup, palette
// loads and RLE/raw frame bytes, with a span predictor checked beat by beat at the output.
// Depends on prpd_pkg and the decoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prpd_pkg::*;

  localparam int    CLK_PERIOD   = 4;
  localparam int    RESET_CYCLES = 10;
  localparam int    SETTLE       = 8;
  localparam int    LONG_HOLD    = 300;
  localparam int    PHASES       = 12;
  localparam int    PHASE_BEATS  = 100;
  localparam longint LIMIT_NS    = 2_000_000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  typedef struct {
    mode_e      mode;
    logic [7:0] pal_idx;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] data;
    bit         drain;
  } beat_t;

  typedef struct {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic [SPAN_W-1:0] span_len;
    logic              frame_end;
  } span_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              mode_i = 1'b0;
  logic [7:0]        pal_index_i = '0;
  logic [7:0]        pal_blue_i = '0;
  logic [7:0]        pal_green_i = '0;
  logic [7:0]        pal_red_i = '0;
  logic [7:0]        data_byte_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        red_o;
  logic [7:0]        green_o;
  logic [7:0]        blue_o;
  logic [7:0]        alpha_o;
  logic [SPAN_W-1:0] span_length_o;
  logic              frame_end_o;

  palette_rle_pixel_decoder_core i_dut (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // decoder shadow state
  logic [23:0] palette_rgb [PALETTE_ENTRIES];
  logic [7:0]  clear_idx = '0;
  bit          clear_found;
  bit          want_count;
  int unsigned pix_done;
  logic [15:0] cfg_w = 16'd1;
  logic [15:0] cfg_h = 16'd1;
  logic [7:0]  cfg_marker = '0;
  bit          cfg_raw;

  // stimulus-side view, runs ahead of acceptance
  bit          gen_written [PALETTE_ENTRIES];
  bit          gen_wait;
  logic [7:0]  gen_clear = '0;
  bit          gen_found;

  beat_t beat_queue[$];
  span_t pending_spans[$];
  int    fail_count;
  bit    long_hold_req;

  task automatic emit_span(input logic [7:0] idx, input bit may_clear, input int unsigned count);
    int unsigned total;
    int unsigned left;
    int unsigned len;
    bit          transparent;
    span_t       sp;
    total = 32'(cfg_w) * 32'(cfg_h);
    if (total == 0) total = 1;
    left = (pix_done < total) ? total - pix_done : 1;
    len = (count < left) ? count : left;
    transparent = may_clear && (idx == clear_idx);
    sp.red       = transparent ? 8'h00 : palette_rgb[idx][23:16];
    sp.green     = transparent ? 8'h00 : palette_rgb[idx][15:8];
    sp.blue      = transparent ? 8'h00 : palette_rgb[idx][7:0];
    sp.alpha     = transparent ? 8'h00 : ALPHA_OPAQUE;
    sp.span_len  = SPAN_W'(len);
    sp.frame_end = (len == left);
    if (sp.frame_end) begin
      pix_done = 0;
      want_count = 1'b0;
    end else begin
      pix_done += len;
    end
    pending_spans.push_back(sp);
  endtask

  task automatic decode_beat(input beat_t bt);
    if (bt.mode == MODE_PAL) begin
      palette_rgb[bt.pal_idx] = {bt.red, bt.green, bt.blue};
      if (bt.blue == 8'h00 && bt.green == 8'hff && bt.red == 8'h00 &&
          (!clear_found || bt.pal_idx < clear_idx)) begin
        clear_idx = bt.pal_idx;
        clear_found = 1'b1;
      end
    end else if (cfg_raw) begin
      emit_span(bt.data, 1'b0, 1);
    end else if (want_count) begin
      want_count = 1'b0;
      emit_span(cfg_marker, 1'b1, int'(bt.data) + 1);
    end else if (bt.data == cfg_marker) begin
      want_count = 1'b1;
    end else begin
      emit_span(bt.data, 1'b1, 1);
    end
  endtask

  // sender: bursts with random gaps
  beat_t beat_now;
  int    gap_left;
  int    burst_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) decode_beat(beat_now);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (beat_queue.size() != 0 &&
                     !(beat_queue[0].drain && pending_spans.size() != 0)) begin
          beat_now = beat_queue.pop_front();
          mode_i      <= beat_now.mode;
          pal_index_i <= beat_now.pal_idx;
          pal_blue_i  <= beat_now.blue;
          pal_green_i <= beat_now.green;
          pal_red_i   <= beat_now.red;
          data_byte_i <= beat_now.data;
          in_valid_i  <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern in modes, plus one long hold
  stall_mode_e stall_mode = STALL_NONE;
  int          mode_left;
  int          hold_left;
  bit          hold_taken;
  int unsigned stall_tick;

  always @(posedge clk_i) begin
    stall_tick++;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (long_hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = LONG_HOLD;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 64);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:     out_stall_i <= 1'b0;
        STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 9) < 7);
        STALL_PERIODIC: out_stall_i <= (stall_tick % 4 == 0);
        default:        out_stall_i <= 1'b0;
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [8:0] want,
                                      input logic [8:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  span_t span_exp;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_spans.size() == 0) begin
        $display({"%0t ns: unexpected span beat, expected none, ",
                  "actual r%0h g%0h b%0h a%0h len %0d end %0b"},
                 $time, red_o, green_o, blue_o, alpha_o, span_length_o, frame_end_o);
        fail_count++;
      end else begin
        span_exp = pending_spans.pop_front();
        check_field("red", 9'(span_exp.red), 9'(red_o));
        check_field("green", 9'(span_exp.green), 9'(green_o));
        check_field("blue", 9'(span_exp.blue), 9'(blue_o));
        check_field("alpha", 9'(span_exp.alpha), 9'(alpha_o));
        check_field("span_length", span_exp.span_len, span_length_o);
        check_field("frame_end", 9'(span_exp.frame_end), 9'(frame_end_o));
      end
    end
  end

  task automatic reg_write(input reg_e which, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * int'(which));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (which)
      REG_WIDTH:  cfg_w = value[15:0];
      REG_HEIGHT: cfg_h = value[15:0];
      REG_MARKER: cfg_marker = value[7:0];
      REG_RAW:    cfg_raw = value[0];
      default:    ;
    endcase
    pix_done = 0;
    want_count = 1'b0;
    gen_wait = 1'b0;
  endtask

  task automatic set_frame(input logic [15:0] w, input logic [15:0] h,
                           input logic [7:0] marker, input bit raw);
    reg_write(REG_WIDTH, 32'(w));
    reg_write(REG_HEIGHT, 32'(h));
    reg_write(REG_MARKER, 32'(marker));
    reg_write(REG_RAW, 32'(raw));
  endtask

  task automatic queue_pal(input logic [7:0] idx, input logic [7:0] b, input logic [7:0] g,
                           input logic [7:0] r);
    beat_t bt;
    bt.mode    = MODE_PAL;
    bt.pal_idx = idx;
    bt.blue    = b;
    bt.green   = g;
    bt.red     = r;
    bt.data    = 8'($urandom);
    bt.drain   = 1'b0;
    beat_queue.push_back(bt);
    gen_written[idx] = 1'b1;
    if (b == 8'h00 && g == 8'hff && r == 8'h00 && (!gen_found || idx < gen_clear)) begin
      gen_clear = idx;
      gen_found = 1'b1;
    end
  endtask

  task automatic queue_data(input logic [7:0] value, input bit drain);
    beat_t bt;
    bt.mode    = MODE_DATA;
    bt.pal_idx = 8'($urandom);
    bt.blue    = 8'($urandom);
    bt.green   = 8'($urandom);
    bt.red     = 8'($urandom);
    bt.data    = value;
    bt.drain   = drain;
    beat_queue.push_back(bt);
    if (!cfg_raw) begin
      if (gen_wait) gen_wait = 1'b0;
      else if (value == cfg_marker) gen_wait = 1'b1;
    end
  endtask

  // never picks an index whose palette entry is still unwritten
  function automatic logic [7:0] pick_data();
    logic [7:0] v;
    int         sel;
    sel = $urandom_range(0, 9);
    if (!cfg_raw && gen_wait) begin
      if (sel == 0) return 8'h00;
      if (sel == 1) return 8'hff;
      return (sel < 6) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    end
    if (!cfg_raw && sel < 2) return cfg_marker;
    if (sel == 2 && gen_written[gen_clear]) return gen_clear;
    do v = 8'($urandom_range(0, 255)); while (!gen_written[v]);
    return v;
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (beat_queue.size() != 0 || in_valid_i || pending_spans.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_dim();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'd0;
    if (sel == 1) return 16'hffff;
    return 16'($urandom_range(1, 12));
  endfunction

  initial begin : stimulus
    bit         green;
    logic [7:0] idx;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one-pixel frames, marker 0, no green entry yet so index 0 is clear
    queue_pal(8'd0, 8'hff, 8'hff, 8'hff);
    queue_pal(8'd255, 8'h12, 8'h34, 8'h56);
    queue_pal(8'd7, 8'h01, 8'h80, 8'hfe);
    queue_data(8'd7, 1'b0);
    queue_data(8'd255, 1'b0);
    queue_data(8'd0, 1'b0);
    queue_data(8'd0, 1'b0);
    queue_pal(8'd200, 8'h00, 8'hff, 8'h00);
    queue_pal(8'd100, 8'h00, 8'hff, 8'h00);
    queue_pal(8'd150, 8'h00, 8'hff, 8'h00);
    queue_pal(8'd100, 8'h00, 8'h00, 8'hff);
    queue_data(8'd100, 1'b0);
    queue_data(8'd150, 1'b0);
    wait_idle();

    // 3x2 frame, marker 255: clipped run, partial runs, palette beat inside a run
    set_frame(16'd3, 16'd2, 8'hff, 1'b0);
    queue_data(8'hff, 1'b0);
    queue_data(8'hff, 1'b0);
    queue_data(8'hff, 1'b0);
    queue_data(8'd3, 1'b0);
    queue_data(8'd7, 1'b1);
    queue_data(8'd0, 1'b0);
    queue_data(8'hff, 1'b0);
    queue_pal(8'd7, 8'h55, 8'haa, 8'h33);
    queue_data(8'd1, 1'b0);
    wait_idle();

    // raw, zero width: one-pixel frames, clear index shows opaque
    set_frame(16'd0, 16'hffff, 8'h00, 1'b1);
    queue_data(8'd100, 1'b0);
    queue_data(8'hff, 1'b0);
    wait_idle();

    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      green = ($urandom_range(0, 15) == 0);
      queue_pal(8'(i), green ? 8'h00 : 8'($urandom), green ? 8'hff : 8'($urandom),
                green ? 8'h00 : 8'($urandom));
    end
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) set_frame(16'hffff, 16'hffff, 8'($urandom), 1'b0);
      else set_frame(pick_dim(), pick_dim(), ($urandom_range(0, 3) == 0) ?
                     (($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff) : 8'($urandom),
                     ($urandom_range(0, 3) == 0));
      if (p == 3) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(0, 11) == 0) begin
          green = ($urandom_range(0, 5) == 0);
          idx = 8'($urandom);
          queue_pal(idx, green ? 8'h00 : 8'($urandom), green ? 8'hff : 8'($urandom),
                    green ? 8'h00 : 8'($urandom));
        end else begin
          queue_data(pick_data(), ($urandom_range(0, 59) == 0));
        end
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/prpd_pkg.sv
hdl/prpd_cfg_regs.sv
hdl/prpd_palette.sv
hdl/prpd_span.sv
hdl/palette_rle_pixel_decoder_core.sv
tb/tb.sv
